@@ sv/met_pkg.sv @@
// Shared constants, register codes and types of the Mandelbrot escape-time unit.
package met_pkg;

	localparam int IMAGE_WIDTH = 337;
	localparam int IMAGE_HEIGHT = 217;
	localparam int FRAC_BITS = 12;

	localparam int PIX_W = 9;
	localparam int START_W = 16;
	localparam int SPAN_W = 17;
	localparam int ITER_W = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 17;
	localparam int IN_DATA_W = 24;
	localparam int OUT_DATA_W = 8;

	// span * pixel as a signed product, and the bits its magnitude needs.
	localparam int PROD_W = SPAN_W + PIX_W + 1;
	localparam int MAG_W = SPAN_W + PIX_W;

	// Division by the image size as a multiply by a rounded-up reciprocal.
	localparam int SHIFT_X = MAG_W + $clog2(IMAGE_WIDTH);
	localparam int SHIFT_Y = MAG_W + $clog2(IMAGE_HEIGHT);
	localparam longint RECIP_X = ((longint'(1) << SHIFT_X) + IMAGE_WIDTH - 1) / IMAGE_WIDTH;
	localparam longint RECIP_Y = ((longint'(1) << SHIFT_Y) + IMAGE_HEIGHT - 1) / IMAGE_HEIGHT;
	localparam int RECIP_W = MAG_W + 2;
	localparam int QPROD_W = MAG_W + RECIP_W;

	// Coordinate width: largest offset, start and the swing an unescaped orbit adds.
	localparam int IMG_MIN = (IMAGE_WIDTH < IMAGE_HEIGHT) ? IMAGE_WIDTH : IMAGE_HEIGHT;
	localparam int QMAX = (2 ** (MAG_W - 1)) / IMG_MIN;
	localparam int ESC_MARGIN = 3 << (FRAC_BITS + 3);
	localparam int COORD_W = $clog2(QMAX + (2 ** (START_W - 1)) + ESC_MARGIN) + 1;
	localparam int SQ_W = 2 * COORD_W - FRAC_BITS;
	localparam int FOUR = 4 << FRAC_BITS;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_REAL_START = 3'd0,
		REG_REAL_SPAN  = 3'd1,
		REG_IMAG_START = 3'd2,
		REG_IMAG_SPAN  = 3'd3,
		REG_MAX_ITER   = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
	} met_coord_t;

	typedef struct packed {
		logic signed [START_W-1:0] real_start;
		logic signed [SPAN_W-1:0]  real_span;
		logic signed [START_W-1:0] imag_start;
		logic signed [SPAN_W-1:0]  imag_span;
	} met_view_t;

endpackage

@@ sv/met_map.sv @@
// Three-stage pipeline that maps a pixel to its point c in the complex plane.
module met_map (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [met_pkg::PIX_W-1:0]  pixel_x,
	input  logic [met_pkg::PIX_W-1:0]  pixel_y,
	input  met_pkg::met_view_t         view,
	output logic                       out_valid,
	input  logic                       out_ready,
	output met_pkg::met_coord_t        coord
);

	logic v_s1, v_s2, v_s3;
	logic rdy_s1, rdy_s2, rdy_s3;

	logic signed [met_pkg::PROD_W-1:0]  px_s1, py_s1;
	logic                               nx_s2, ny_s2;
	logic        [met_pkg::QPROD_W-1:0] qx_s2, qy_s2;
	met_pkg::met_coord_t                c_s3;

	logic [met_pkg::PROD_W-1:0]  ax, ay;
	logic [met_pkg::MAG_W-1:0]   qx, qy;
	logic signed [met_pkg::COORD_W-1:0] ox, oy;

	assign rdy_s3 = !v_s3 || out_ready;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// Stage 2 works on magnitudes so that the quotient truncates toward zero.
	always_comb begin
		ax = px_s1[met_pkg::PROD_W-1] ? met_pkg::PROD_W'(-px_s1) : met_pkg::PROD_W'(px_s1);
		ay = py_s1[met_pkg::PROD_W-1] ? met_pkg::PROD_W'(-py_s1) : met_pkg::PROD_W'(py_s1);
		qx = met_pkg::MAG_W'(qx_s2 >> met_pkg::SHIFT_X);
		qy = met_pkg::MAG_W'(qy_s2 >> met_pkg::SHIFT_Y);
		ox = nx_s2 ? -$signed(met_pkg::COORD_W'(qx)) : $signed(met_pkg::COORD_W'(qx));
		oy = ny_s2 ? -$signed(met_pkg::COORD_W'(qy)) : $signed(met_pkg::COORD_W'(qy));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			px_s1 <= met_pkg::PROD_W'(view.real_span * $signed({1'b0, pixel_x}));
			py_s1 <= met_pkg::PROD_W'(view.imag_span * $signed({1'b0, pixel_y}));
		end
		if (rdy_s2 && v_s1) begin
			nx_s2 <= px_s1[met_pkg::PROD_W-1];
			ny_s2 <= py_s1[met_pkg::PROD_W-1];
			qx_s2 <= met_pkg::QPROD_W'(ax[met_pkg::MAG_W-1:0])
				* met_pkg::QPROD_W'(met_pkg::RECIP_X);
			qy_s2 <= met_pkg::QPROD_W'(ay[met_pkg::MAG_W-1:0])
				* met_pkg::QPROD_W'(met_pkg::RECIP_Y);
		end
		if (rdy_s3 && v_s2) begin
			c_s3.cx <= met_pkg::COORD_W'(view.real_start) + ox;
			c_s3.cy <= met_pkg::COORD_W'(view.imag_start) + oy;
		end
	end

	assign out_valid = v_s3;
	assign coord = c_s3;

endmodule

@@ sv/met_iter.sv @@
// Four-stage iteration ring that holds up to four pixels and retires them in order.
module met_iter (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  met_pkg::met_coord_t         coord,
	input  logic [met_pkg::ITER_W-1:0]  max_iter,
	output logic                        res_valid,
	input  logic                        res_ready,
	output logic [met_pkg::ITER_W-1:0]  res_count
);

	localparam int CW = met_pkg::COORD_W;
	localparam int PW = 2 * met_pkg::COORD_W;
	localparam int SW = met_pkg::SQ_W;
	localparam int IW = met_pkg::ITER_W;

	// Sequence tags: one bit wider than the ring so that a full ring is visible.
	logic [2:0] in_seq_q, ret_seq_q;

	logic                 out_v_q;
	logic [IW-1:0]        out_cnt_q;

	// Ring entry, combinational.
	logic                 e_v;
	logic signed [CW-1:0] e_x, e_y, e_cx, e_cy;
	logic signed [SW-1:0] e_xsq, e_ysq;
	logic [IW-1:0]        e_cnt, e_lim;
	logic                 e_done;
	logic [1:0]           e_seq;

	logic                 v_s1, v_s2, v_s3, v_s4;
	logic signed [PW-1:0] pxy_s1;
	logic signed [CW-1:0] xn_s1, cx_s1, cy_s1;
	logic [IW-1:0]        cnt_s1, lim_s1;
	logic                 done_s1;
	logic [1:0]           seq_s1;

	logic signed [CW-1:0] xn_s2, yn_s2, cx_s2, cy_s2;
	logic [IW-1:0]        cnt_s2, lim_s2;
	logic                 done_s2;
	logic [1:0]           seq_s2;

	logic signed [PW-1:0] sx_s3, sy_s3;
	logic signed [CW-1:0] xn_s3, yn_s3, cx_s3, cy_s3;
	logic [IW-1:0]        cnt_s3, lim_s3;
	logic                 done_s3;
	logic [1:0]           seq_s3;

	logic signed [CW-1:0] x_s4, y_s4, cx_s4, cy_s4;
	logic signed [SW-1:0] xsq_s4, ysq_s4;
	logic [IW-1:0]        cnt_s4, lim_s4;
	logic                 done_s4;
	logic [1:0]           seq_s4;

	logic                 out_space, retire, slot_free, take;
	logic signed [SW-1:0] xsq_n, ysq_n;
	logic signed [SW:0]   mag_n;
	logic [IW-1:0]        cnt_n;
	logic [IW:0]          cnt_inc;
	logic signed [PW-1:0] yn_wide;

	assign out_space = !out_v_q || res_ready;
	assign retire = v_s4 && done_s4 && (seq_s4 == ret_seq_q[1:0]) && out_space;
	assign slot_free = !v_s4 || retire;
	assign take = slot_free && in_valid;
	assign in_ready = slot_free;

	always_comb begin
		if (take) begin
			e_v = 1'b1;
			e_x = '0;
			e_y = '0;
			e_xsq = '0;
			e_ysq = '0;
			e_cx = coord.cx;
			e_cy = coord.cy;
			e_cnt = '0;
			e_lim = max_iter;
			e_done = 1'b0;
			e_seq = in_seq_q[1:0];
		end else begin
			e_v = v_s4 && !retire;
			e_x = x_s4;
			e_y = y_s4;
			e_xsq = xsq_s4;
			e_ysq = ysq_s4;
			e_cx = cx_s4;
			e_cy = cy_s4;
			e_cnt = cnt_s4;
			e_lim = lim_s4;
			e_done = done_s4;
			e_seq = seq_s4;
		end
	end

	// Forms the new y for stage 2; exit stage: squares back to Q12, bump the count and test for escape.
	always_comb begin
		yn_wide = ((pxy_s1 >>> met_pkg::FRAC_BITS) <<< 1) + PW'(cy_s1);
		xsq_n = SW'(sx_s3 >>> met_pkg::FRAC_BITS);
		ysq_n = SW'(sy_s3 >>> met_pkg::FRAC_BITS);
		mag_n = (SW+1)'(xsq_n) + (SW+1)'(ysq_n);
		cnt_inc = (IW+1)'(cnt_s3) + (IW+1)'(1);
		cnt_n = done_s3 ? cnt_s3 : cnt_inc[IW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			in_seq_q <= '0;
			ret_seq_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			v_s1 <= e_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			if (take) in_seq_q <= in_seq_q + 3'd1;
			if (retire) ret_seq_q <= ret_seq_q + 3'd1;
			if (retire) out_v_q <= 1'b1;
			else if (res_ready) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		pxy_s1 <= PW'(e_x) * PW'(e_y);
		xn_s1 <= CW'(e_xsq - e_ysq + SW'(e_cx));
		cx_s1 <= e_cx;
		cy_s1 <= e_cy;
		cnt_s1 <= e_cnt;
		lim_s1 <= e_lim;
		done_s1 <= e_done;
		seq_s1 <= e_seq;

		xn_s2 <= xn_s1;
		yn_s2 <= CW'(yn_wide);
		cx_s2 <= cx_s1;
		cy_s2 <= cy_s1;
		cnt_s2 <= cnt_s1;
		lim_s2 <= lim_s1;
		done_s2 <= done_s1;
		seq_s2 <= seq_s1;

		sx_s3 <= PW'(xn_s2) * PW'(xn_s2);
		sy_s3 <= PW'(yn_s2) * PW'(yn_s2);
		xn_s3 <= xn_s2;
		yn_s3 <= yn_s2;
		cx_s3 <= cx_s2;
		cy_s3 <= cy_s2;
		cnt_s3 <= cnt_s2;
		lim_s3 <= lim_s2;
		done_s3 <= done_s2;
		seq_s3 <= seq_s2;

		x_s4 <= xn_s3;
		y_s4 <= yn_s3;
		xsq_s4 <= xsq_n;
		ysq_s4 <= ysq_n;
		cx_s4 <= cx_s3;
		cy_s4 <= cy_s3;
		cnt_s4 <= cnt_n;
		lim_s4 <= lim_s3;
		done_s4 <= done_s3 || (cnt_n >= lim_s3) || (mag_n >= (SW+1)'(met_pkg::FOUR));
		seq_s4 <= seq_s3;

		if (retire) out_cnt_q <= cnt_s4;
	end

	assign res_valid = out_v_q;
	assign res_count = out_cnt_q;

	// The tag distance always equals the number of pixels in the ring.
	a_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_seq_q - ret_seq_q) == 3'($countones({v_s1, v_s2, v_s3, v_s4})))
		else $error("ring occupancy does not match sequence tags");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		retire |=> (res_valid && res_count != '0))
		else $error("retired pixel carries a zero count");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && !done_s4) |-> (cnt_s4 < lim_s4))
		else $error("pixel kept iterating past its limit");

endmodule

@@ sv/mandelbrot_escape_time_q12.sv @@
// Top level of the Mandelbrot escape-time unit: registers, mapping and iteration ring.
// Each pixel item is mapped to c by the mapping pipeline, then iterates in a four-stage
// ring (multiply, add, square, escape test) that holds up to four pixels at once, so one
// iteration per cycle is done overall while the ring holds four unfinished pixels. A pixel's
// count n runs from 1 to max_iter (1 when max_iter is 0); the ring takes new items while
// earlier pixels still iterate, and results leave in input order, so a slow pixel holds
// those behind it.
module mandelbrot_escape_time_q12 (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [met_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // pixel_x, pixel_y
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [met_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // iter_count
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [met_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [met_pkg::CFG_DATA_W-1:0]     cfg_data
);

	met_pkg::met_view_t          view_q;
	logic [met_pkg::ITER_W-1:0]  max_iter_q;

	logic                        map_valid, map_ready;
	met_pkg::met_coord_t         map_coord;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_q.real_start <= -16'sd8192;
			view_q.real_span <= 17'sd12288;
			view_q.imag_start <= -16'sd4096;
			view_q.imag_span <= 17'sd8192;
			max_iter_q <= 8'd64;
		end else if (cfg_valid) begin
			unique case (met_pkg::cfg_reg_t'(cfg_index))
				met_pkg::REG_REAL_START: view_q.real_start <= cfg_data[met_pkg::START_W-1:0];
				met_pkg::REG_REAL_SPAN:  view_q.real_span <= cfg_data[met_pkg::SPAN_W-1:0];
				met_pkg::REG_IMAG_START: view_q.imag_start <= cfg_data[met_pkg::START_W-1:0];
				met_pkg::REG_IMAG_SPAN:  view_q.imag_span <= cfg_data[met_pkg::SPAN_W-1:0];
				met_pkg::REG_MAX_ITER:   max_iter_q <= cfg_data[met_pkg::ITER_W-1:0];
				default: ;
			endcase
		end
	end

	met_map u_map (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.pixel_x   (s_axis_tdata[met_pkg::PIX_W-1:0]),
		.pixel_y   (s_axis_tdata[2*met_pkg::PIX_W-1:met_pkg::PIX_W]),
		.view      (view_q),
		.out_valid (map_valid),
		.out_ready (map_ready),
		.coord     (map_coord)
	);

	met_iter u_iter (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (map_valid),
		.in_ready  (map_ready),
		.coord     (map_coord),
		.max_iter  (max_iter_q),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res_count (m_axis_tdata)
	);

endmodule

@@ tb/mandelbrot_escape_time_q12_tb.sv @@
// Self-checking testbench of the Mandelbrot escape-time unit.
module mandelbrot_escape_time_q12_tb;

	localparam int STALL_LIMIT = 40000;
	localparam int LONG_HOLD = 3000;
	localparam int SETTLE = 4 * 255 + 20;
	localparam logic [met_pkg::CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
	localparam logic [met_pkg::CFG_IDX_W-1:0] REG_SPARE_LAST = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [met_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;   // pixel_x, pixel_y
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [met_pkg::OUT_DATA_W-1:0] m_axis_tdata;       // iter_count
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [met_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [met_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// Copy of the view registers that the predictor uses.
	logic signed [met_pkg::START_W-1:0] view_real_start = -16'sd8192;
	logic signed [met_pkg::SPAN_W-1:0] view_real_span = 17'sd12288;
	logic signed [met_pkg::START_W-1:0] view_imag_start = -16'sd4096;
	logic signed [met_pkg::SPAN_W-1:0] view_imag_span = 17'sd8192;
	logic [met_pkg::ITER_W-1:0] view_max_iter = 8'd64;

	logic [met_pkg::ITER_W-1:0] pending_counts[$];
	int errors = 0;
	int pixels_sent = 0;
	int counts_checked = 0;
	int src_idle_pct = 0;
	int snk_idle_pct = 0;
	int hold_request = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	mandelbrot_escape_time_q12 dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	function automatic logic [met_pkg::ITER_W-1:0] escape_count(
			input logic [met_pkg::PIX_W-1:0] px, input logic [met_pkg::PIX_W-1:0] py);
		longint cx, cy, x, y, xsq, ysq, four;
		int unsigned count, limit;
		cx = longint'(view_real_start)
			+ (longint'(view_real_span) * longint'(px)) / longint'(met_pkg::IMAGE_WIDTH);
		cy = longint'(view_imag_start)
			+ (longint'(view_imag_span) * longint'(py)) / longint'(met_pkg::IMAGE_HEIGHT);
		four = longint'(4) << met_pkg::FRAC_BITS;
		x = 0; y = 0; xsq = 0; ysq = 0;
		count = 0;
		limit = view_max_iter;
		forever begin
			y = ((x * y) >>> met_pkg::FRAC_BITS) * 2 + cy;
			x = xsq - ysq + cx;
			xsq = (x * x) >>> met_pkg::FRAC_BITS;
			ysq = (y * y) >>> met_pkg::FRAC_BITS;
			count++;
			if (count >= limit || xsq + ysq >= four)
				break;
		end
		return count[met_pkg::ITER_W-1:0];
	endfunction

	task automatic send_pixel(input logic [met_pkg::PIX_W-1:0] px,
			input logic [met_pkg::PIX_W-1:0] py);
		if ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(met_pkg::IN_DATA_W - 2 * met_pkg::PIX_W){1'b0}}, py, px};
		do @(posedge clk); while (!s_axis_tready);
		pending_counts.push_back(escape_count(px, py));
		pixels_sent++;
	endtask

	// Lets the unit empty out so the registers may be written.
	task automatic drain;
		s_axis_tvalid <= 1'b0;
		while (pending_counts.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [met_pkg::CFG_IDX_W-1:0] idx,
			input logic [met_pkg::CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			met_pkg::REG_REAL_START: view_real_start = value[met_pkg::START_W-1:0];
			met_pkg::REG_REAL_SPAN:  view_real_span = value;
			met_pkg::REG_IMAG_START: view_imag_start = value[met_pkg::START_W-1:0];
			met_pkg::REG_IMAG_SPAN:  view_imag_span = value;
			met_pkg::REG_MAX_ITER:   view_max_iter = value[met_pkg::ITER_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_view(input int rs, input int rsp, input int is, input int isp, input int mi);
		write_reg(met_pkg::REG_REAL_START, met_pkg::CFG_DATA_W'(rs));
		write_reg(met_pkg::REG_REAL_SPAN, met_pkg::CFG_DATA_W'(rsp));
		write_reg(met_pkg::REG_IMAG_START, met_pkg::CFG_DATA_W'(is));
		write_reg(met_pkg::REG_IMAG_SPAN, met_pkg::CFG_DATA_W'(isp));
		write_reg(met_pkg::REG_MAX_ITER, met_pkg::CFG_DATA_W'(mi));
	endtask

	// Corners, edges, pixels past the image and alternating bit patterns at reset values.
	task automatic test_default_view;
		send_pixel(9'd0, 9'd0);
		send_pixel(9'd511, 9'd511);
		send_pixel(9'd336, 9'd216);
		send_pixel(9'd337, 9'd217);
		send_pixel(9'd0, 9'd511);
		send_pixel(9'd511, 9'd0);
		send_pixel(9'd168, 9'd108);
		send_pixel(9'd224, 9'd108);
		send_pixel(9'h155, 9'h0AA);
		send_pixel(9'h0AA, 9'h155);
		drain();
	endtask

	// Register extremes, zero limit, mirrored view and writes to unused indexes.
	task automatic test_register_extremes;
		set_view(-32768, -65536, 32767, 65535, 0);
		send_pixel(9'd0, 9'd0);
		send_pixel(9'd511, 9'd511);
		drain();
		set_view(32767, 65535, -32768, -65536, 1);
		send_pixel(9'd336, 9'd0);
		send_pixel(9'd0, 9'd216);
		drain();
		set_view(4096, -12288, 4096, -8192, 255);
		send_pixel(9'd200, 9'd108);
		send_pixel(9'd50, 9'd60);
		send_pixel(9'd300, 9'd30);
		drain();
		for (int i = REG_SPARE_FIRST; i <= REG_SPARE_LAST; i++)
			write_reg(met_pkg::CFG_IDX_W'(i), met_pkg::CFG_DATA_W'($urandom));
		send_pixel(9'd120, 9'd100);
		send_pixel(9'd10, 9'd200);
		drain();
	endtask

	task automatic random_view;
		if ($urandom_range(9) == 0)
			set_view($urandom_range(65535) - 32768, $urandom_range(131071) - 65536,
				$urandom_range(65535) - 32768, $urandom_range(131071) - 65536,
				$urandom_range(255));
		else
			set_view($urandom_range(6000) - 10000, $urandom_range(14000) - 2000,
				$urandom_range(6000) - 6000, $urandom_range(10000) - 1000,
				($urandom_range(15) == 0) ? $urandom_range(100, 255) : $urandom_range(1, 48));
	endtask

	task automatic test_random_pixels(input int n, input int src_pct, input int snk_pct);
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		for (int i = 0; i < n; i++) begin
			if (i % 110 == 0) begin
				drain();
				random_view();
			end
			if ($urandom_range(7) == 0)
				send_pixel(met_pkg::PIX_W'($urandom), met_pkg::PIX_W'($urandom));
			else
				send_pixel(met_pkg::PIX_W'($urandom_range(met_pkg::IMAGE_WIDTH - 1)),
					met_pkg::PIX_W'($urandom_range(met_pkg::IMAGE_HEIGHT - 1)));
		end
		drain();
	endtask

	// The output is held off while items keep coming, then the input waits for all counts.
	task automatic test_backpressure;
		src_idle_pct = 0;
		snk_idle_pct = 0;
		set_view(-8192, 12288, -4096, 8192, 64);
		hold_request = LONG_HOLD;
		for (int i = 0; i < 16; i++)
			send_pixel(met_pkg::PIX_W'($urandom_range(met_pkg::IMAGE_WIDTH - 1)),
				met_pkg::PIX_W'($urandom_range(met_pkg::IMAGE_HEIGHT - 1)));
		drain();
		for (int i = 0; i < 6; i++)
			send_pixel(met_pkg::PIX_W'($urandom_range(met_pkg::IMAGE_WIDTH - 1)),
				met_pkg::PIX_W'($urandom_range(met_pkg::IMAGE_HEIGHT - 1)));
		drain();
	endtask

	// Result side: random stalls, the long hold, and the comparison of every count.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_counts.size() == 0) begin
				$display("%0t: unexpected iter_count %0d", $time, m_axis_tdata);
				errors++;
			end else begin
				logic [met_pkg::ITER_W-1:0] want;
				want = pending_counts.pop_front();
				if (m_axis_tdata[met_pkg::ITER_W-1:0] !== want) begin
					$display("%0t: iter_count mismatch, expected %0d, actual %0d",
						$time, want, m_axis_tdata);
					errors++;
				end
				counts_checked++;
			end
		end
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("%0t: timeout, no item moved for %0d cycles", $time, STALL_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_default_view();
		test_register_extremes();
		test_random_pixels(650, 11, 77);
		test_random_pixels(650, 77, 11);
		test_random_pixels(700, 0, 0);
		test_backpressure();
		repeat (SETTLE) @(posedge clk);
		$display("Sent %0d pixels and checked %0d escape counts over many views,", pixels_sent,
			counts_checked);
		$display("including extreme registers, zero limit, mirrored spans and a long stall.");
		if (errors == 0 && pending_counts.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
